>>> sv/two_slot_event_counter_allocator_macros.svh
// Assertion macros shared by the event-counter allocator RTL.
`ifndef TWO_SLOT_EVENT_COUNTER_ALLOCATOR_MACROS_SVH
`define TWO_SLOT_EVENT_COUNTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TSEC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("allocator check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TSEC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("allocator sequencing check failed");

`endif

>>> sv/tsec_pkg.sv
`timescale 1ns / 1ps

package tsec_pkg;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_DEALLOC = 3'd1;
   localparam logic [2:0] ACT_QUERY   = 3'd2;
   localparam logic [2:0] ACT_START   = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;
   localparam logic [2:0] ACT_STOP    = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONE      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] RUN_NONE = 2'd0;
   localparam logic [1:0] RUN_SET  = 2'd1;
   localparam logic [1:0] RUN_STOP = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  event_code;
      logic [31:0] counter0_value;
      logic [31:0] counter1_value;
   } tsec_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        slot;
      logic [31:0] delta;
      logic        program_event;
      logic        clear_counter;
      logic [1:0]  run_request;
   } tsec_rsp_type;

   typedef struct packed {
      logic [1:0]       slot_assigned;
      logic [1:0][7:0]  slot_event;
      logic [1:0][31:0] last_count;
   } tsec_state_type;

   // Write strobes and data for the slot registers, one bit per slot.
   typedef struct packed {
      logic [1:0]  assign_set;
      logic [1:0]  assign_clr;
      logic [1:0]  event_we;
      logic [7:0]  event_value;
      logic [1:0]  count_we;
      logic [31:0] count_value;
   } tsec_upd_type;

endpackage

>>> sv/tsec_op_unit.sv
`timescale 1ns / 1ps

module tsec_op_unit import tsec_pkg::*; (
   input  tsec_req_type   req,
   input  tsec_state_type state,
   output tsec_rsp_type   rsp,
   output tsec_upd_type   upd
);

   logic        match0;
   logic        match1;
   logic        hit;
   logic        hit_slot;
   logic [31:0] cur_count;
   logic [31:0] prev_count;
   logic [1:0]  hit_mask;

   // Slot 0 wins when both slots hold the same event.
   assign match0     = state.slot_assigned[0] && (state.slot_event[0] == req.event_code);
   assign match1     = state.slot_assigned[1] && (state.slot_event[1] == req.event_code);
   assign hit        = match0 || match1;
   assign hit_slot   = !match0;
   assign hit_mask   = match0 ? 2'b01 : (match1 ? 2'b10 : 2'b00);
   assign cur_count  = hit_slot ? req.counter1_value : req.counter0_value;
   assign prev_count = state.last_count[hit_slot];

   always_comb begin
      rsp = '0;
      upd = '0;
      upd.event_value = req.event_code;
      upd.count_value = 32'd0;
      case (req.action)
         ACT_ALLOC: begin
            if (!state.slot_assigned[0]) begin
               upd.assign_set = 2'b01;
               upd.event_we   = 2'b01;
            end else if (!state.slot_assigned[1]) begin
               upd.assign_set = 2'b10;
               upd.event_we   = 2'b10;
               rsp.slot       = 1'b1;
            end else begin
               rsp.status = ST_NONE;
            end
         end
         ACT_DEALLOC: begin
            if (hit) begin
               upd.assign_clr = hit_mask;
               rsp.slot       = hit_slot;
            end else begin
               rsp.status = ST_NONE;
            end
         end
         ACT_QUERY: begin
            if (hit) begin
               rsp.slot = hit_slot;
            end else begin
               rsp.status = ST_NONE;
            end
         end
         ACT_START: begin
            if (hit) begin
               upd.count_we      = hit_mask;
               rsp.slot          = hit_slot;
               rsp.program_event = 1'b1;
               rsp.clear_counter = 1'b1;
               rsp.run_request   = RUN_SET;
            end else begin
               rsp.status = ST_NONE;
            end
         end
         ACT_READ: begin
            if (hit) begin
               // Plain modulo 2^32 difference handles counter wrap.
               rsp.delta       = cur_count - prev_count;
               rsp.slot        = hit_slot;
               upd.count_we    = hit_mask;
               upd.count_value = cur_count;
            end else begin
               rsp.status = ST_NOT_FOUND;
            end
         end
         ACT_STOP: begin
            if (state.slot_assigned == 2'b00) begin
               rsp.run_request = RUN_STOP;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/tsec_slot_regs.sv
`timescale 1ns / 1ps

module tsec_slot_regs import tsec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           update_en,
   input  tsec_upd_type   upd,
   output tsec_state_type state
);

   tsec_state_type state_ff;
   tsec_state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (update_en) begin
         for (int i = 0; i < 2; i++) begin
            if (upd.assign_set[i]) state_in.slot_assigned[i] = 1'b1;
            if (upd.assign_clr[i]) state_in.slot_assigned[i] = 1'b0;
            if (upd.event_we[i])   state_in.slot_event[i]    = upd.event_value;
            if (upd.count_we[i])   state_in.last_count[i]    = upd.count_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

>>> sv/two_slot_event_counter_allocator.sv
`timescale 1ns / 1ps
// Channel    Ports                         Transfer
// request    start, busy, req_data         start high and busy low at a rising edge
// response   rsp_strobe, rsp_data          rsp_strobe high for one cycle
//
// One operation per cycle: the request is registered, decoded against the two
// slot registers in one pass, and the result register loads at the next edge and
// drives the response transfer.
// The slot compare and the 32-bit delta subtract set that path.
// Synchronous reset frees both slots and clears last counts and event codes.
// busy stays low; the response side cannot stall, so nothing backs up.

`include "two_slot_event_counter_allocator_macros.svh"

module two_slot_event_counter_allocator import tsec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  tsec_req_type req_data,
   output logic         rsp_strobe,
   output tsec_rsp_type rsp_data
);

   logic           req_valid_ff;
   logic           req_valid_in;
   tsec_req_type   req_ff;
   tsec_req_type   req_in;
   logic           rsp_valid_ff;
   tsec_rsp_type   rsp_ff;
   tsec_rsp_type   rsp_in;
   tsec_upd_type   upd;
   tsec_state_type state;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign req_in       = req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) req_ff <= req_in;
      if (req_valid_ff) rsp_ff <= rsp_in;
   end

   tsec_op_unit u_op (
      .req   (req_ff),
      .state (state),
      .rsp   (rsp_in),
      .upd   (upd)
   );

   tsec_slot_regs u_slots (
      .clock     (clock),
      .reset     (reset),
      .update_en (req_valid_ff),
      .upd       (upd),
      .state     (state)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Every accepted request produces a response once it has passed the request and result registers.
   `TSEC_ASSERT_NEXT(a_rsp_follows_req, clock, reset, start && !busy, ##1 rsp_strobe)
   // A start request always comes with the clear and run requests.
   `TSEC_ASSERT_IMPLIES(a_start_flags, clock, reset, rsp_strobe && rsp_data.program_event,
      rsp_data.clear_counter && rsp_data.run_request == RUN_SET && rsp_data.status == ST_OK)
   // A nonzero delta only comes from a read.
   `TSEC_ASSERT_IMPLIES(a_delta_from_read, clock, reset, rsp_strobe && rsp_data.delta != 32'd0,
      $past(req_ff.action) == ACT_READ)
   // A successful allocate leaves the reported slot assigned.
   `TSEC_ASSERT_IMPLIES(a_alloc_marks_slot, clock, reset,
      rsp_strobe && $past(req_ff.action) == ACT_ALLOC && rsp_data.status == ST_OK,
      state.slot_assigned[rsp_data.slot])

endmodule

>>> sim/two_slot_event_counter_allocator_tb.sv
`timescale 1ns / 1ps

module two_slot_event_counter_allocator_tb;
   import tsec_pkg::*;

   // The two action codes that the block ignores.
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS   = 650;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;

   class slot_scoreboard;
      bit           used[2];
      logic [7:0]   held_event[2];
      logic [31:0]  prior_count[2];
      tsec_rsp_type awaited_rsp[$];
      int           mismatch_count;

      function new();
         for (int i = 0; i < 2; i++) begin
            used[i] = 1'b0;
            held_event[i] = '0;
            prior_count[i] = '0;
         end
         mismatch_count = 0;
      endfunction

      task report_mismatch(input string msg);
         mismatch_count++;
         $display("ERROR at %0t: %s", $realtime, msg);
      endtask

      function int match_slot(input logic [7:0] ev);
         if (used[0] && held_event[0] == ev) return 0;
         if (used[1] && held_event[1] == ev) return 1;
         return -1;
      endfunction

      function tsec_rsp_type predict_response(input tsec_req_type r);
         tsec_rsp_type o;
         int           hit;
         logic [31:0]  now_count;
         o = '0;
         hit = match_slot(r.event_code);
         case (r.action)
            ACT_ALLOC: begin
               if (!used[0]) begin
                  used[0] = 1'b1;
                  held_event[0] = r.event_code;
               end else if (!used[1]) begin
                  used[1] = 1'b1;
                  held_event[1] = r.event_code;
                  o.slot = 1'b1;
               end else begin
                  o.status = ST_NONE;
               end
            end
            ACT_DEALLOC: begin
               if (hit < 0) begin
                  o.status = ST_NONE;
               end else begin
                  used[hit] = 1'b0;
                  o.slot = (hit == 1);
               end
            end
            ACT_QUERY: begin
               if (hit < 0) o.status = ST_NONE;
               else o.slot = (hit == 1);
            end
            ACT_START: begin
               if (hit < 0) begin
                  o.status = ST_NONE;
               end else begin
                  prior_count[hit] = '0;
                  o.slot = (hit == 1);
                  o.program_event = 1'b1;
                  o.clear_counter = 1'b1;
                  o.run_request = RUN_SET;
               end
            end
            ACT_READ: begin
               if (hit < 0) begin
                  o.status = ST_NOT_FOUND;
               end else begin
                  now_count = (hit == 1) ? r.counter1_value : r.counter0_value;
                  // Plain 32-bit subtraction covers the wrap-around case.
                  o.delta = now_count - prior_count[hit];
                  prior_count[hit] = now_count;
                  o.slot = (hit == 1);
               end
            end
            ACT_STOP: begin
               if (!used[0] && !used[1]) o.run_request = RUN_STOP;
            end
            default: begin
            end
         endcase
         return o;
      endfunction

      function void note_request(input tsec_req_type r);
         awaited_rsp.push_back(predict_response(r));
      endfunction

      task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_response(input tsec_rsp_type got);
         tsec_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response strobe with no outstanding request");
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("slot", 32'(got.slot), 32'(want.slot));
            check_field("delta", got.delta, want.delta);
            check_field("program_event", 32'(got.program_event), 32'(want.program_event));
            check_field("clear_counter", 32'(got.clear_counter), 32'(want.clear_counter));
            check_field("run_request", 32'(got.run_request), 32'(want.run_request));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   tsec_req_type req_data = '0;
   logic         rsp_strobe;
   tsec_rsp_type rsp_data;

   slot_scoreboard board;
   int           idle_pct = 23;
   int           quiet_cycles = 0;
   logic [7:0]   event_pool[3];

   two_slot_event_counter_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic tsec_req_type make_req(input logic [2:0] act, input logic [7:0] ev,
                                             input logic [31:0] c0, input logic [31:0] c1);
      tsec_req_type r;
      r.action = act;
      r.event_code = ev;
      r.counter0_value = c0;
      r.counter1_value = c1;
      return r;
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // A small pool of events keeps matches frequent; sometimes two entries agree
   // so that both slots end up holding the same event.
   function automatic void refresh_pool();
      for (int i = 0; i < 3; i++) event_pool[i] = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) event_pool[1] = event_pool[0];
   endfunction

   function automatic tsec_req_type random_request();
      tsec_req_type r;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 20) r.action = ACT_ALLOC;
      else if (pick < 35) r.action = ACT_DEALLOC;
      else if (pick < 45) r.action = ACT_QUERY;
      else if (pick < 60) r.action = ACT_START;
      else if (pick < 85) r.action = ACT_READ;
      else if (pick < 95) r.action = ACT_STOP;
      else r.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
      if ($urandom_range(9) < 8) r.event_code = event_pool[$urandom_range(2)];
      else r.event_code = 8'($urandom_range(255));
      r.counter0_value = rand_count();
      r.counter1_value = rand_count();
      return r;
   endfunction

   // Holds the request on the port until the transfer happens at a rising edge.
   task automatic send_request(input tsec_req_type r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data <= random_request();
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_data);
         if (rsp_strobe) board.check_response(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   initial begin
      tsec_req_type r;
      int           sent;
      board = new();
      refresh_pool();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 23;
      send_request(make_req(ACT_STOP, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_READ, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(ACT_QUERY, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_DEALLOC, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_START, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_ALLOC, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_ALLOC, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_ALLOC, 8'h5A, 32'h0, 32'h0));
      send_request(make_req(ACT_STOP, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_QUERY, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_START, 8'h00, 32'h0, 32'h0));
      send_request(make_req(ACT_READ, 8'h00, 32'hFFFF_FFFF, 32'h0));
      // The counter has wrapped since the last read.
      send_request(make_req(ACT_READ, 8'h00, 32'h0000_0005, 32'hFFFF_FFFF));
      send_request(make_req(ACT_START, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_READ, 8'hFF, 32'h0, 32'hFFFF_FFFF));
      send_request(make_req(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(ACT_DEALLOC, 8'h00, 32'h0, 32'h0));
      // Same event in both slots; slot 0 has to win every search.
      send_request(make_req(ACT_ALLOC, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_QUERY, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_READ, 8'hFF, 32'h1234_5678, 32'h8765_4321));
      send_request(make_req(ACT_DEALLOC, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_QUERY, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_SPARE_A, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(ACT_SPARE_B, 8'h00, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(ACT_DEALLOC, 8'hFF, 32'h0, 32'h0));
      send_request(make_req(ACT_STOP, 8'hFF, 32'h0, 32'h0));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) idle_pct = 23;
         else if (sent < 2 * RANDOM_ITEMS / 3) idle_pct = 54;
         else idle_pct = 0;
         if ($urandom_range(39) == 0) refresh_pool();
         r = random_request();
         send_request(r);
         if (r.action <= ACT_STOP) sent++;
      end
      start <= 1'b0;

      while (board.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/tsec_pkg.sv
sv/tsec_op_unit.sv
sv/tsec_slot_regs.sv
sv/two_slot_event_counter_allocator.sv
sim/two_slot_event_counter_allocator_tb.sv
